>>> design/sida_pkg.sv
// shared types and constants for the signed integer to decimal ascii block
// no dependencies
package sida_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DigitIdxW     = 4;
  localparam int unsigned BcdWidth      = 4 * NumDigits;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumStages     = 4;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [3:0] MaxDigit  = 4'd9;

  // one beat moving through the conversion pipeline
  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] bin;
    logic [BcdWidth-1:0]   bcd;
  } sida_beat_t;

endpackage

>>> design/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii text, one character per beat
// depends on sida_pkg, sida_dabble_stage, sida_emitter
//
// A value is taken at a rising edge where start is high and busy is low. It goes
// through a sign/magnitude register and four double dabble stages of eight shift
// steps each before the emitter registers it and sends its first character. The
// characters then come out on consecutive cycles, most significant first, each
// marked by char_valid_o for exactly one cycle; the receiver must take every
// beat, there is no back pressure on the output. A negative number starts with
// '-', zero gives a single '0', leading zeros never appear, and end_mark_o marks
// the final character. The emitter sends one character per cycle and takes the next
// number only with the final character of the one before; that sets the sustained
// rate. The conversion stages take a new value every cycle while the stage ahead
// can move on, and fill up behind a busy emitter; busy drops as soon as the input
// register can move on; reset clears only the pipeline valid bits and emitter state.
module signed_int_to_decimal_ascii import sida_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  char_valid_o,
  output logic [7:0]            char_code_o,
  output logic                  end_mark_o
);

  // input register: sign and magnitude
  logic                  in_valid_q, in_valid_d;
  logic                  in_neg_q;
  logic [ValueWidth-1:0] in_mag_q;
  logic                  in_load;

  // pipeline links, index 0 is the input register output
  logic       link_valid [NumStages+1];
  sida_beat_t link_beat  [NumStages+1];
  logic       link_ready [NumStages+1];

  assign busy    = in_valid_q && !link_ready[0];
  assign in_load = start && !busy;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (link_ready[0]) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // two's complement magnitude, the most negative value maps to 2^31 unsigned
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_neg_q <= value_i[ValueWidth-1];
      in_mag_q <= value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;
    end
  end

  assign link_valid[0]    = in_valid_q;
  assign link_beat[0].neg = in_neg_q;
  assign link_beat[0].bin = in_mag_q;
  assign link_beat[0].bcd = '0;

  // double dabble stages
  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    sida_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[g]),
      .beat_i  (link_beat[g]),
      .ready_o (link_ready[g]),
      .valid_o (link_valid[g+1]),
      .beat_o  (link_beat[g+1]),
      .ready_i (link_ready[g+1])
    );
  end

  // character output
  sida_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (link_valid[NumStages]),
    .beat_i       (link_beat[NumStages]),
    .ready_o      (link_ready[NumStages]),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .end_mark_o   (end_mark_o)
  );

  // accepted value always lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_load |=> in_valid_q)
    else $error("accepted value not captured");

  // last marker only rides on a valid character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_mark_o |-> char_valid_o)
    else $error("last marker without a character");

  // busy only while the input register holds a stalled value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> in_valid_q)
    else $error("busy without a held value");

endmodule

>>> design/sida_dabble_stage.sv
// one register stage of the double dabble conversion, eight shift steps per stage
// depends on sida_pkg
module sida_dabble_stage import sida_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  sida_beat_t beat_i,
  output logic       ready_o,
  output logic       valid_o,
  output sida_beat_t beat_o,
  input  logic       ready_i
);

  logic       valid_q, valid_d;
  sida_beat_t beat_q, beat_d;
  logic       load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
    bcd = beat_i.bcd;
    bin = beat_i.bin;
    for (int s = 0; s < StepsPerStage; s++) begin
      // add-3 correction on every digit of 5 or more, then shift one bit in
      for (int k = 0; k < NumDigits; k++) begin
        if (bcd[4*k +: 4] >= 4'd5) begin
          bcd[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BcdWidth-2:0], bin[ValueWidth-1]};
      bin = {bin[ValueWidth-2:0], 1'b0};
    end
    beat_d.neg = beat_i.neg;
    beat_d.bin = bin;
    beat_d.bcd = bcd;
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  // a stalled beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(beat_q))
    else $error("dabble stage lost or changed a stalled beat");

  // an accepted beat shows up in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_o)
    else $error("dabble stage dropped an accepted beat");

  // an empty stage always takes a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> ready_o)
    else $error("empty dabble stage refused a beat");

endmodule

>>> design/sida_emitter.sv
// character emitter: strips leading zeros and sends sign and digits one per cycle
// depends on sida_pkg
module sida_emitter import sida_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  sida_beat_t beat_i,
  output logic       ready_o,
  output logic       char_valid_o,
  output logic [7:0] char_code_o,
  output logic       end_mark_o
);

  logic                            active_q, active_d;
  logic                            neg_q, neg_d;
  logic [DigitIdxW-1:0]            idx_q, idx_d;
  logic [NumDigits-1:0][3:0]       dig_q;
  logic [DigitIdxW-1:0]            lead;
  logic                            load;
  logic                            final_beat;
  logic [3:0]                      cur_dig;

  assign cur_dig    = dig_q[idx_q];
  assign final_beat = active_q && !neg_q && (idx_q == '0);
  assign ready_o    = !active_q || final_beat;
  assign load       = valid_i && ready_o;

  // highest nonzero digit, zero gives digit 0
  always_comb begin
    lead = '0;
    for (int k = 0; k < NumDigits; k++) begin
      if (beat_i.bcd[4*k +: 4] != 4'd0) begin
        lead = DigitIdxW'(k);
      end
    end
  end

  always_comb begin
    active_d = active_q;
    neg_d    = neg_q;
    idx_d    = idx_q;
    if (active_q) begin
      if (neg_q) begin
        neg_d = 1'b0;
      end else if (idx_q == '0) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
    if (load) begin
      active_d = 1'b1;
      neg_d    = beat_i.neg;
      idx_d    = lead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      neg_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      neg_q    <= neg_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= beat_i.bcd;
    end
  end

  assign char_valid_o = active_q;
  assign char_code_o  = neg_q ? CharMinus : (CharZero + {4'd0, cur_dig});
  assign end_mark_o   = final_beat;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && neg_q |-> !end_mark_o)
    else $error("minus sign marked as last character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && !neg_q |-> cur_dig <= MaxDigit)
    else $error("emitted digit out of decimal range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> char_valid_o && ($past(beat_i.neg) == neg_q))
    else $error("loaded number did not start emitting");

endmodule

>>> dv/tb_top.sv
// self-checking bench for signed_int_to_decimal_ascii: directed corners, then random numbers
// depends on sida_pkg and the signed_int_to_decimal_ascii top level
module tb_top import sida_pkg::*; ;

  // one character beat as the block should emit it
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  localparam int unsigned Radix          = 10;
  localparam int unsigned ItemsPerPhase  = 97;
  localparam int unsigned SettleCycles   = 20;
  localparam int unsigned TimeoutUnits   = 4_000_000;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  logic [ValueWidth-1:0] value_i = '0;
  logic                  char_valid_o;
  logic [7:0]            char_code_o;
  logic                  end_mark_o;

  logic [ValueWidth-1:0] pending_values_q[$];   // numbers waiting to be offered
  ascii_char_t           expected_chars_q[$];   // characters still owed by the block

  int unsigned sender_idle_pct = 0;             // chance per cycle that start stays low
  int unsigned error_count     = 0;
  int unsigned numbers_taken   = 0;
  int unsigned negatives_taken = 0;
  int unsigned chars_checked   = 0;
  bit [10:0]   lengths_seen    = '0;            // one bit per text length 1..11

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .char_valid_o(char_valid_o),
    .char_code_o (char_code_o),
    .end_mark_o  (end_mark_o)
  );

  // 20 unit period, rising edges at 10, 30, ...
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // decimal text of one number: optional minus, then digits most significant first
  function automatic void spell_decimal(input logic [ValueWidth-1:0] value);
    logic [ValueWidth-1:0] magnitude;
    logic [3:0]            digits[NumDigits];
    int                    n_digits;
    ascii_char_t           ch;
    // two's complement negate; the most negative value stays 2^31 as unsigned
    magnitude = value[ValueWidth-1] ? (~value + 1'b1) : value;
    n_digits  = 0;
    do begin
      digits[n_digits] = 4'(magnitude % Radix);
      magnitude        = magnitude / Radix;
      n_digits++;
    end while (magnitude != 0);
    if (value[ValueWidth-1]) begin
      ch.code = CharMinus;
      ch.last = 1'b0;
      expected_chars_q.push_back(ch);
      negatives_taken++;
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.code = CharZero + 8'(digits[i]);
      ch.last = (i == 0);
      expected_chars_q.push_back(ch);
    end
    lengths_seen[n_digits + int'(value[ValueWidth-1]) - 1] = 1'b1;
  endfunction

  // mostly numbers of a chosen digit count, so every text length turns up often;
  // a quarter are raw 32-bit patterns so every input bit toggles
  function automatic logic [ValueWidth-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     n_digits;
    bit     negative;
    if ($urandom_range(3) == 0) begin
      return $urandom();
    end
    n_digits = $urandom_range(1, NumDigits);
    negative = $urandom_range(1);
    lo = (n_digits == 1) ? 0 : longint'(10) ** (n_digits - 1);
    hi = longint'(10) ** n_digits - 1;
    if (hi > 64'sd2147483648) begin
      hi = negative ? 64'sd2147483648 : 64'sd2147483647;
    end
    mag = lo + longint'($urandom() % (hi - lo + 1));
    return negative ? ValueWidth'(-mag) : ValueWidth'(mag);
  endfunction

  // driver: a number is taken at an edge with start high and busy low;
  // start is assigned once per edge so a back-to-back item never glitches low
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      value_i <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        spell_decimal(value_i);
        numbers_taken++;
      end
      if (pending_values_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start   <= 1'b1;
        value_i <= pending_values_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed character is taken, the receiver has no say
  always @(posedge clk_i) begin
    ascii_char_t want;
    if (rst_ni && char_valid_o) begin
      if (expected_chars_q.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h end %b", char_code_o, end_mark_o));
      end else begin
        want = expected_chars_q.pop_front();
        chars_checked++;
        if (char_code_o !== want.code) begin
          report_mismatch($sformatf("char_code 0x%02h, want 0x%02h", char_code_o, want.code));
        end
        if (end_mark_o !== want.last) begin
          report_mismatch($sformatf("end_mark %b, want %b", end_mark_o, want.last));
        end
      end
    end
  end

  // waits until every number was taken and every owed character came out
  task automatic wait_drained();
    while (pending_values_q.size() != 0 || start || expected_chars_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_random_phase(input int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (ItemsPerPhase) pending_values_q.push_back(random_value());
    // the phase returns only once the block has said everything
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners: zero, single digits, digit carries, both extremes
    sender_idle_pct = 0;
    pending_values_q = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd12345, -32'sd54321, 32'd999999999, -32'sd999999999, 32'd1000000000,
      -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'd4000000000, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1000000007
    };
    wait_drained();

    // random phases: back to back, sender sparse, again back to back, sender rarely idle
    run_random_phase(0);
    run_random_phase(63);
    run_random_phase(0);
    run_random_phase(6);

    // let any stray late beat show up
    repeat (SettleCycles) @(posedge clk_i);

    $display("converted %0d numbers (%0d negative), checked %0d characters",
             numbers_taken, negatives_taken, chars_checked);
    $display("text lengths 1..11 seen: %b (bit 0 = one character)", lengths_seen);
    if (error_count == 0 && expected_chars_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop if the handshake hangs
  initial begin
    #TimeoutUnits;
    $display("timeout with %0d numbers pending, %0d characters owed",
             pending_values_q.size(), expected_chars_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
